/* rtl/pal_pkg.sv */
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants of the positional array list
// Sizes of the entry row, field widths and the operation codes.
// ----------------------------------------------------------------------------
package pal_pkg;

	localparam int CAPACITY  = 16;
	localparam int WORD_BITS = 32;

	localparam int MODE_W  = 2;
	localparam int POS_W   = 5;
	localparam int VALUE_W = 32;
	localparam int LIM_W   = 5;
	localparam int CNT_W   = $clog2(CAPACITY + 1);

	// Width that holds the position, the count, the limit and every cell index.
	localparam int CMP_W0 = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int CMP_W  = (CMP_W0 > LIM_W) ? CMP_W0 : LIM_W;

	localparam int IN_BITS  = MODE_W + POS_W + VALUE_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 1 + VALUE_W + CNT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(16);

	typedef enum logic [MODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_GET    = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_op_t;

	typedef struct packed {
		logic               status;
		logic [VALUE_W-1:0] read_value;
		logic [CNT_W-1:0]   item_count;
	} result_t;

endpackage

/* rtl/pal_cell.sv */
// ----------------------------------------------------------------------------
// pal_cell: one slot of the entry row
// Holds one word; loads a new word or takes its left or right neighbor's word.
// ----------------------------------------------------------------------------
module pal_cell (
	input  logic                           clk,
	input  pal_pkg::cell_op_t              op,
	input  logic [pal_pkg::WORD_BITS-1:0]  load_word,
	input  logic [pal_pkg::WORD_BITS-1:0]  left_word,
	input  logic [pal_pkg::WORD_BITS-1:0]  right_word,
	output logic [pal_pkg::WORD_BITS-1:0]  word
);

	logic [pal_pkg::WORD_BITS-1:0] word_q;

	always_ff @(posedge clk) begin
		case (op)
			pal_pkg::CELL_LOAD:       word_q <= load_word;
			pal_pkg::CELL_FROM_LEFT:  word_q <= left_word;
			pal_pkg::CELL_FROM_RIGHT: word_q <= right_word;
			default:                  word_q <= word_q;
		endcase
	end

	assign word = word_q;

endmodule

/* rtl/pal_ctrl.sv */
// ----------------------------------------------------------------------------
// pal_ctrl: operation decode and length register
// Checks bounds, keeps the count and tells every cell how to move this cycle.
// ----------------------------------------------------------------------------
module pal_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [pal_pkg::MODE_W-1:0]    mode,
	input  logic [pal_pkg::POS_W-1:0]     position,
	input  logic [pal_pkg::LIM_W-1:0]     list_limit,
	input  logic [pal_pkg::WORD_BITS-1:0] words [pal_pkg::CAPACITY],
	output pal_pkg::cell_op_t             cell_ops [pal_pkg::CAPACITY],
	output pal_pkg::result_t              result
);

	localparam int CMP_W = pal_pkg::CMP_W;
	localparam logic [CMP_W-1:0] CAP_X = CMP_W'(pal_pkg::CAPACITY);

	logic [pal_pkg::CNT_W-1:0] count_q;
	logic [pal_pkg::CNT_W-1:0] count_d;
	logic [CMP_W-1:0]          pos_x;
	logic [CMP_W-1:0]          cnt_x;
	logic [CMP_W-1:0]          lim_x;
	logic [pal_pkg::WORD_BITS-1:0] rd_word;
	logic                      in_range;

	assign pos_x    = CMP_W'(position);
	assign cnt_x    = CMP_W'(count_q);
	assign lim_x    = (CMP_W'(list_limit) > CAP_X) ? CAP_X : CMP_W'(list_limit);
	assign in_range = pos_x < cnt_x;

	// AND-OR select of the cell at the requested position.
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < pal_pkg::CAPACITY; i++) begin
			if (pos_x == CMP_W'(i))
				rd_word = rd_word | words[i];
		end
	end

	always_comb begin
		result.status     = 1'b1;
		result.read_value = '0;
		count_d           = count_q;
		for (int i = 0; i < pal_pkg::CAPACITY; i++)
			cell_ops[i] = pal_pkg::CELL_HOLD;
		case (pal_pkg::op_t'(mode))
			pal_pkg::OP_INSERT: begin
				if (pos_x <= cnt_x && cnt_x < lim_x && cnt_x < CAP_X) begin
					result.status = 1'b0;
					count_d       = count_q + pal_pkg::CNT_W'(1);
					// Cells above the position take their lower neighbor's word.
					for (int i = 0; i < pal_pkg::CAPACITY; i++) begin
						if (CMP_W'(i) == pos_x)
							cell_ops[i] = pal_pkg::CELL_LOAD;
						else if (CMP_W'(i) > pos_x)
							cell_ops[i] = pal_pkg::CELL_FROM_LEFT;
					end
				end
			end
			pal_pkg::OP_GET: begin
				if (in_range) begin
					result.status     = 1'b0;
					result.read_value = pal_pkg::VALUE_W'(rd_word);
				end
			end
			pal_pkg::OP_DELETE: begin
				if (in_range) begin
					result.status = 1'b0;
					count_d       = count_q - pal_pkg::CNT_W'(1);
					for (int i = 0; i < pal_pkg::CAPACITY; i++) begin
						if (CMP_W'(i) >= pos_x)
							cell_ops[i] = pal_pkg::CELL_FROM_RIGHT;
					end
				end
			end
			default: begin
				result.status = 1'b0;
				count_d       = '0;
			end
		endcase
		if (!fire) begin
			for (int i = 0; i < pal_pkg::CAPACITY; i++)
				cell_ops[i] = pal_pkg::CELL_HOLD;
		end
		result.item_count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pal_pkg::CNT_W'(pal_pkg::CAPACITY))
		else $error("list length exceeds capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode == pal_pkg::OP_CLEAR |=> count_q == '0)
		else $error("clear did not empty the list");

	a_refused_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.status |=> count_q == $past(count_q))
		else $error("refused operation changed the length");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode == pal_pkg::OP_INSERT && !result.status
		|=> count_q == $past(count_q) + pal_pkg::CNT_W'(1))
		else $error("insert did not grow the list by one");

endmodule

/* rtl/positional_array_list.sv */
// ----------------------------------------------------------------------------
// positional_array_list: fixed-capacity ordered list of words
// Insert, get, delete and clear by position over a row of shifting cells.
// ----------------------------------------------------------------------------
// Requests arrive as words on the s_ channel and each one returns exactly one
// result word on the m_ channel, in order. A request is executed in the cycle
// it is accepted: every cell of the row shifts at once, so an insert or a
// delete takes no longer than a get. The result sits in an output register
// and appears on m_tvalid the cycle after acceptance. A new request is taken
// in the same cycle the waiting result is taken, so the block sustains one
// request per cycle while the receiver keeps up. When the receiver stalls, the
// result holds and s_tready drops until it is taken; no request is lost or
// executed twice. The capacity in use is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle, which the block does
// not enforce. Values above CAPACITY act as CAPACITY. Reset empties the list
// and sets the capacity in use to its maximum. Entry storage is not cleared;
// only entries below the length are ever read.
// ----------------------------------------------------------------------------
module positional_array_list (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pal_pkg::LIM_W-1:0]   cfg_wdata,   // list_limit
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [pal_pkg::IN_W-1:0]    s_tdata,     // mode, position, value
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [pal_pkg::OUT_W-1:0]   m_tdata      // status, read_value, item_count
);

	localparam int CAP = pal_pkg::CAPACITY;
	localparam int WB  = pal_pkg::WORD_BITS;

	logic [pal_pkg::LIM_W-1:0]   list_limit_q;
	logic                        out_valid_q;
	pal_pkg::result_t            out_q;
	pal_pkg::result_t            result;
	logic                        fire;
	logic [pal_pkg::MODE_W-1:0]  in_mode;
	logic [pal_pkg::POS_W-1:0]   in_position;
	logic [pal_pkg::VALUE_W-1:0] in_value;
	logic [WB-1:0]               load_word;
	logic [WB-1:0]               words [CAP];
	pal_pkg::cell_op_t           cell_ops [CAP];

	assign in_mode     = s_tdata[pal_pkg::MODE_W-1:0];
	assign in_position = s_tdata[pal_pkg::MODE_W +: pal_pkg::POS_W];
	assign in_value    = s_tdata[pal_pkg::MODE_W + pal_pkg::POS_W +: pal_pkg::VALUE_W];
	assign load_word   = WB'(in_value);

	assign s_tready = !out_valid_q || m_tready;
	assign fire     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_limit_q <= pal_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			list_limit_q <= cfg_wdata;
		end
	end

	pal_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.mode       (in_mode),
		.position   (in_position),
		.list_limit (list_limit_q),
		.words      (words),
		.cell_ops   (cell_ops),
		.result     (result)
	);

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic [WB-1:0] left_word;
		logic [WB-1:0] right_word;

		if (i == 0) begin : g_first
			assign left_word = '0;
		end else begin : g_left
			assign left_word = words[i-1];
		end
		if (i == CAP - 1) begin : g_last
			assign right_word = '0;
		end else begin : g_right
			assign right_word = words[i+1];
		end

		pal_cell u_cell (
			.clk        (clk),
			.op         (cell_ops[i]),
			.load_word  (load_word),
			.left_word  (left_word),
			.right_word (right_word),
			.word       (words[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			out_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = pal_pkg::OUT_W'({out_q.item_count, out_q.read_value, out_q.status});

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("accepted request produced no result word");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> !fire || $past(fire) == 1'b0 || m_tvalid)
		else $error("result word dropped while stalled");

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !s_tready)
		else $error("request accepted while output register is occupied");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the positional array list
// Sends insert, get, delete and clear words under several list limits. A
// shadow copy of the list in the bench predicts each result word. Both stream
// sides idle at random, and one phase holds the result side off for a long
// stretch.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic                        status;
		logic [pal_pkg::VALUE_W-1:0] read_value;
		logic [pal_pkg::CNT_W-1:0]   item_count;
	} list_answer_t;

	localparam int HOLD_CYCLES = 400;

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [pal_pkg::LIM_W-1:0]  cfg_wdata = '0;
	logic                       s_tvalid  = 1'b0;
	logic                       s_tready;
	logic [pal_pkg::IN_W-1:0]   s_tdata   = '0;   // mode, position, value, zero pad
	logic                       m_tvalid;
	logic                       m_tready  = 1'b0;
	logic [pal_pkg::OUT_W-1:0]  m_tdata;          // status, read_value, item_count, zero pad

	// Shadow copy of the list and its limit.
	logic [pal_pkg::VALUE_W-1:0] shadow_words [pal_pkg::CAPACITY];
	int                          shadow_len   = 0;
	logic [pal_pkg::LIM_W-1:0]   shadow_limit = pal_pkg::LIMIT_RESET;

	list_answer_t answers_due [$];

	int  mismatches  = 0;
	int  ops_sent [4] = '{0, 0, 0, 0};
	int  refused     = 0;
	int  results_got = 0;
	int  peak_len    = 0;
	int  limits_set  = 0;
	bit  idle_on     = 1'b1;
	int  hold_asked  = 0;
	int  hold_taken  = 0;
	int  hold_left   = 0;
	int  stall_left  = 0;

	positional_array_list u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#800000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < 40)
			$display("mismatch: %s got 0x%0h expected 0x%0h", what, got, want);
		mismatches++;
	endtask

	// Applies one request to the shadow list and returns the word it should produce.
	function automatic list_answer_t apply_to_shadow_list(input pal_pkg::op_t op,
			input logic [pal_pkg::POS_W-1:0] pos, input logic [pal_pkg::VALUE_W-1:0] val);
		list_answer_t ans;
		int lim;
		int p;
		ans.status     = 1'b1;
		ans.read_value = '0;
		lim = shadow_limit;
		if (lim > pal_pkg::CAPACITY)
			lim = pal_pkg::CAPACITY;
		p = pos;
		case (op)
			pal_pkg::OP_INSERT: begin
				if (p <= shadow_len && shadow_len < lim) begin
					for (int i = shadow_len; i > p; i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[p] = val;
					shadow_len++;
					ans.status = 1'b0;
				end
			end
			pal_pkg::OP_GET: begin
				if (p < shadow_len) begin
					ans.read_value = shadow_words[p];
					ans.status     = 1'b0;
				end
			end
			pal_pkg::OP_DELETE: begin
				if (p < shadow_len) begin
					for (int i = p + 1; i < shadow_len; i++)
						shadow_words[i-1] = shadow_words[i];
					shadow_len--;
					ans.status = 1'b0;
				end
			end
			default: begin
				shadow_len = 0;
				ans.status = 1'b0;
			end
		endcase
		ans.item_count = pal_pkg::CNT_W'(shadow_len);
		return ans;
	endfunction

	task automatic send_request(input pal_pkg::op_t op, input logic [pal_pkg::POS_W-1:0] pos,
			input logic [pal_pkg::VALUE_W-1:0] val);
		list_answer_t ans;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(pal_pkg::IN_W-pal_pkg::IN_BITS){1'b0}}, val, pos, op};
		do @(posedge clk); while (s_tready !== 1'b1);
		ans = apply_to_shadow_list(op, pos, val);
		answers_due.push_back(ans);
		ops_sent[op]++;
		if (ans.status)
			refused++;
		if (shadow_len > peak_len)
			peak_len = shadow_len;
	endtask

	// Stops offering words and waits until every pending result word is back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_limit(input logic [pal_pkg::LIM_W-1:0] lim);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we       <= 1'b0;
		shadow_limit = lim;
		limits_set++;
	endtask

	function automatic logic [pal_pkg::VALUE_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly positions that the list accepts, with some out-of-range ones mixed in.
	task automatic send_random_requests(input int n, input int insert_pct);
		int r;
		pal_pkg::op_t op;
		logic [pal_pkg::POS_W-1:0] pos;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				op = pal_pkg::OP_CLEAR;
			else if (r < 2 + insert_pct)
				op = pal_pkg::OP_INSERT;
			else if ($urandom_range(0, 9) < 6)
				op = pal_pkg::OP_GET;
			else
				op = pal_pkg::OP_DELETE;
			if ($urandom_range(0, 99) < 85) begin
				if (op == pal_pkg::OP_INSERT)
					pos = pal_pkg::POS_W'($urandom_range(0, shadow_len));
				else if (shadow_len > 0)
					pos = pal_pkg::POS_W'($urandom_range(0, shadow_len - 1));
				else
					pos = pal_pkg::POS_W'($urandom_range(0, 31));
			end else begin
				pos = pal_pkg::POS_W'($urandom_range(0, 31));
			end
			send_request(op, pos, pick_word());
		end
	endtask

	// Result side: checks each word taken and decides tready for the next cycle.
	always @(posedge clk) begin
		list_answer_t want;
		if (m_tvalid === 1'b1 && m_tready) begin
			results_got++;
			if (answers_due.size() == 0) begin
				report_mismatch("result word with no request pending", m_tdata, 0);
			end else begin
				want = answers_due.pop_front();
				if (m_tdata[0] !== want.status)
					report_mismatch("status", m_tdata[0], want.status);
				if (m_tdata[pal_pkg::VALUE_W:1] !== want.read_value)
					report_mismatch("read_value", m_tdata[pal_pkg::VALUE_W:1],
						want.read_value);
				if (m_tdata[pal_pkg::VALUE_W+1 +: pal_pkg::CNT_W] !== want.item_count)
					report_mismatch("item_count",
						m_tdata[pal_pkg::VALUE_W+1 +: pal_pkg::CNT_W], want.item_count);
			end
		end
		if (hold_taken != hold_asked) begin
			hold_taken = hold_asked;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 13) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic test_directed();
		send_request(pal_pkg::OP_GET, 5'd0, 32'h0);
		send_request(pal_pkg::OP_DELETE, 5'd0, 32'h0);
		send_request(pal_pkg::OP_INSERT, 5'd1, 32'h1234_5678);
		send_request(pal_pkg::OP_CLEAR, 5'd0, 32'h0);
		send_request(pal_pkg::OP_INSERT, 5'd0, 32'hFFFF_FFFF);
		send_request(pal_pkg::OP_INSERT, 5'd1, 32'h0000_0000);
		send_request(pal_pkg::OP_INSERT, 5'd1, 32'hAAAA_AAAA);
		send_request(pal_pkg::OP_INSERT, 5'd0, 32'h5555_5555);
		send_request(pal_pkg::OP_GET, 5'd3, 32'h0);
		send_request(pal_pkg::OP_GET, 5'd4, 32'h0);
		send_request(pal_pkg::OP_GET, 5'd31, 32'hFFFF_FFFF);
		send_request(pal_pkg::OP_DELETE, 5'd31, 32'h0);
		send_request(pal_pkg::OP_INSERT, 5'd31, 32'hDEAD_BEEF);
		send_request(pal_pkg::OP_INSERT, 5'd4, 32'h8000_0001);
		send_request(pal_pkg::OP_DELETE, 5'd1, 32'h0);
		send_request(pal_pkg::OP_DELETE, 5'd3, 32'h0);
		send_request(pal_pkg::OP_GET, 5'd0, 32'h0);
		send_request(pal_pkg::OP_GET, 5'd1, 32'h0);
		send_request(pal_pkg::OP_GET, 5'd2, 32'h0);
		send_request(pal_pkg::OP_CLEAR, 5'd17, 32'hFFFF_FFFF);
		send_request(pal_pkg::OP_GET, 5'd0, 32'h0);
	endtask

	task automatic test_random_traffic();
		send_random_requests(300, 55);
	endtask

	// The result side stops taking words while requests keep coming, then the
	// sender waits for the list to catch up before going on.
	task automatic test_backpressure();
		hold_asked <= hold_asked + 1;
		send_random_requests(40, 50);
		drain_results();
		send_random_requests(20, 40);
	endtask

	// The list is not cleared between limits, so some limits land below the count.
	task automatic test_limit_sweep();
		logic [pal_pkg::LIM_W-1:0] sweep [9];
		sweep = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd16, 5'd0, 5'd0, 5'd0};
		for (int i = 6; i < 9; i++)
			sweep[i] = pal_pkg::LIM_W'($urandom_range(1, 16));
		for (int i = 0; i < 9; i++) begin
			set_limit(sweep[i]);
			send_random_requests(80, (i % 2) ? 35 : 60);
		end
	endtask

	task automatic test_steady_stream();
		set_limit(pal_pkg::LIMIT_RESET);
		drain_results();
		idle_on = 1'b0;
		send_random_requests(200, 50);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic();
		test_backpressure();
		test_limit_sweep();
		test_steady_stream();
		drain_results();
		repeat (4) @(posedge clk);
		$display("Sent %0d insert, %0d get, %0d delete and %0d clear words; %0d refused.",
			ops_sent[pal_pkg::OP_INSERT], ops_sent[pal_pkg::OP_GET],
			ops_sent[pal_pkg::OP_DELETE], ops_sent[pal_pkg::OP_CLEAR], refused);
		$display("Checked %0d result words over %0d limit writes; the list peaked at %0d.",
			results_got, limits_set, peak_len);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
